### src/sprite_outline_stencil_macros.svh
// Assertion helpers for the outline stencil checker.
// Both expect signals named clk and rst in the calling scope.
`ifndef SPRITE_OUTLINE_STENCIL_MACROS_SVH
`define SPRITE_OUTLINE_STENCIL_MACROS_SVH

// Same-cycle implication.
`define SOS_CHECK(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SOS_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/sos_pkg.sv
`default_nettype none

package sos_pkg;

  // Input transaction: op code plus indexed pixel.
  typedef struct packed {
    logic       op;
    logic [7:0] pixel_value;
  } pix_t;

  // Output transaction: one RGBA pixel.
  typedef struct packed {
    logic [7:0] out_alpha;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       frame_last;
  } rgba_t;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FILL_RED     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FILL_GREEN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FILL_BLUE    = 3'd4;

  localparam logic [CFG_DATA_W-1:0] WIDTH_RESET  = 9'd16;
  localparam logic [CFG_DATA_W-1:0] HEIGHT_RESET = 9'd16;

  localparam logic [7:0] OPAQUE = 8'hFF;
  localparam logic [7:0] WHITE  = 8'hFF;

  // Output queue
  localparam int OQ_DEPTH = 4;
  localparam int OQ_PW    = 2;
  localparam int OQ_CW    = 3;

endpackage

`default_nettype wire

### src/sos_ram.sv
`default_nettype none

// Simple dual-port RAM, registered read.
module sos_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### src/sos_fifo.sv
`default_nettype none

// Small output queue; the head entry drives the output channel.
module sos_fifo (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  sos_pkg::rgba_t             push_data,
  output logic                       valid,
  input  logic                       stall,
  output sos_pkg::rgba_t             data,
  output logic [sos_pkg::OQ_CW-1:0]  count
);

  sos_pkg::rgba_t            mem [sos_pkg::OQ_DEPTH];
  logic [sos_pkg::OQ_PW-1:0] wptr;
  logic [sos_pkg::OQ_PW-1:0] rptr;
  logic                      pop;

  assign valid = (count != '0);
  assign pop   = valid && !stall;
  assign data  = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + sos_pkg::OQ_PW'(1);
      end
      if (pop) begin
        rptr <= rptr + sos_pkg::OQ_PW'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + sos_pkg::OQ_CW'(1);
        2'b01:   count <= count - sos_pkg::OQ_CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

### src/sprite_outline_stencil.sv
// Result path: the result for pixel (r, c) is formed once the pixel at (r+1, c)
//   (or the matching flush transaction) is accepted; it passes the registered
//   line-store read in stage 1, then the output queue.
// Throughput: one transaction per cycle while pix_stall is low, set by the single
//   line-store read-modify-write per pixel; a 4-entry queue absorbs downstream stalls.
// Reset (rst, synchronous): counters, config and queue return to defaults; the line
//   store is not cleared, since every flag a result uses was written earlier in the frame.
`default_nettype none

module sprite_outline_stencil #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             pix_valid,
  output logic                             pix_stall,
  input  sos_pkg::pix_t                    pix_data,
  output logic                             rgba_valid,
  input  logic                             rgba_stall,
  output sos_pkg::rgba_t                   rgba_data,
  input  logic                             cfg_we,
  input  logic [sos_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sos_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int AW  = $clog2(MAX_WIDTH);        // column address
  localparam int WW  = $clog2(MAX_WIDTH + 1);    // width value incl. MAX_WIDTH
  localparam int HW  = $clog2(MAX_HEIGHT + 1);   // row count incl. MAX_HEIGHT
  localparam int CWW = (WW > sos_pkg::CFG_DATA_W) ? WW : sos_pkg::CFG_DATA_W;
  localparam int CHW = (HW > sos_pkg::CFG_DATA_W) ? HW : sos_pkg::CFG_DATA_W;

  // Stage 1 carries one item while its line-store read completes.
  typedef struct packed {
    logic          valid;
    logic          is_pix;
    logic          z;          // current pixel is zero (the neighbor below)
    logic          emit;
    logic          last;
    logic          cpar;       // parity of the row being output
    logic          has_up;
    logic          has_left;
    logic          has_right;
    logic          fwd_a;      // read at column hit the write in flight
    logic          fwd_b;      // read at column+1 hit the write in flight
    logic [1:0]    fwd_data;
    logic [AW-1:0] col;
  } s1_t;

  // ---------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------
  logic [sos_pkg::CFG_DATA_W-1:0] image_width;
  logic [sos_pkg::CFG_DATA_W-1:0] image_height;
  logic [7:0]                     fill_red;
  logic [7:0]                     fill_green;
  logic [7:0]                     fill_blue;

  // Frame position counters
  logic [AW-1:0] in_col;
  logic [HW-1:0] in_row;
  logic [AW-1:0] out_col;      // flush column of the last row
  logic [WW-1:0] pending;      // flush results still owed

  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;

  // Clamp to 1..MAX; zero counts as one.
  always_comb begin
    if (image_width == '0) begin
      w_eff = WW'(1);
    end else if (CWW'(image_width) > CWW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(image_width);
    end
    if (image_height == '0) begin
      h_eff = HW'(1);
    end else if (CHW'(image_height) > CHW'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(image_height);
    end
  end

  // ---------------------------------------------------------------
  // Stage 0: accept, decide, issue line-store reads
  // ---------------------------------------------------------------
  s1_t                     s1;
  s1_t                     s1_next;
  logic                    accept;
  logic                    pix_is;
  logic                    pix_ok;
  logic                    flush_ok;
  logic                    go;
  logic [AW-1:0]           col0;
  logic [AW-1:0]           raddr_b;
  logic [WW-1:0]           col_next_w;
  logic [HW-1:0]           in_row_next;
  logic                    s1_push;
  logic [sos_pkg::OQ_CW-1:0] q_count;
  logic [sos_pkg::OQ_CW-1:0] occupancy;

  // Line store taps and stage 1 results
  logic [1:0]     rd_a;
  logic [1:0]     rd_b;
  logic [1:0]     ent_a;
  logic [1:0]     ent_b;
  logic           center;
  logic           up_flag;
  logic           right_flag;
  logic           left_flag;
  logic           border;
  logic           wr_en;
  logic [1:0]     wr_data;
  sos_pkg::rgba_t result;

  // Stall when the queue plus the result in stage 1 could overflow.
  assign occupancy = q_count + sos_pkg::OQ_CW'(s1_push);
  assign pix_stall = (occupancy >= sos_pkg::OQ_CW'(sos_pkg::OQ_DEPTH));

  assign accept      = pix_valid && !pix_stall;
  assign pix_is      = (pix_data.op == sos_pkg::OP_PIXEL);
  // Pixels past the frame end and idle flushes change nothing.
  assign pix_ok      = (in_row < h_eff) && (WW'(in_col) < w_eff);
  assign flush_ok    = (pending != '0);
  assign go          = accept && (pix_is ? pix_ok : flush_ok);
  assign col0        = pix_is ? in_col : out_col;
  assign raddr_b     = col0 + AW'(1);
  assign col_next_w  = WW'(col0) + WW'(1);
  assign in_row_next = in_row + HW'(1);

  always_comb begin
    s1_next.valid     = go;
    s1_next.is_pix    = pix_is;
    s1_next.z         = (pix_data.pixel_value == 8'h00);
    // Row 0 pixels only fill the store; every flush gives a result.
    s1_next.emit      = pix_is ? (in_row != '0) : 1'b1;
    s1_next.last      = !pix_is && (pending == WW'(1));
    // Output row is in_row-1 for pixels, the last row for flushes.
    s1_next.cpar      = pix_is ? ~in_row[0] : ~h_eff[0];
    s1_next.has_up    = pix_is ? (in_row > HW'(1)) : (h_eff != HW'(1));
    s1_next.has_left  = (col0 != '0);
    s1_next.has_right = (col_next_w < w_eff);
    s1_next.fwd_a     = wr_en && (s1.col == col0);
    s1_next.fwd_b     = wr_en && (s1.col == raddr_b);
    s1_next.fwd_data  = wr_data;
    s1_next.col       = col0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1 <= '0;
    end else begin
      s1 <= s1_next;
    end
  end

  // Two copies of the line store, written alike: one read at the column,
  // one at the column to its right. Bit p of an entry holds the zero flag
  // of the last row with parity p.
  sos_ram #(
    .WIDTH (2),
    .DEPTH (MAX_WIDTH)
  ) u_store_a (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1.col),
    .wdata (wr_data),
    .re    (go),
    .raddr (col0),
    .rdata (rd_a)
  );

  sos_ram #(
    .WIDTH (2),
    .DEPTH (MAX_WIDTH)
  ) u_store_b (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1.col),
    .wdata (wr_data),
    .re    (go),
    .raddr (raddr_b),
    .rdata (rd_b)
  );

  // ---------------------------------------------------------------
  // Stage 1: classify, write back, queue the result
  // ---------------------------------------------------------------
  assign ent_a      = s1.fwd_a ? s1.fwd_data : rd_a;
  assign ent_b      = s1.fwd_b ? s1.fwd_data : rd_b;
  assign center     = ent_a[s1.cpar];
  assign up_flag    = ent_a[~s1.cpar];
  assign right_flag = ent_b[s1.cpar];

  assign border = (s1.has_left && left_flag) || (s1.has_right && right_flag) ||
                  (s1.has_up && up_flag) || (s1.is_pix && s1.z);

  // Replace the flag two rows back with the new pixel's flag.
  assign wr_en = s1.valid && s1.is_pix;
  always_comb begin
    wr_data           = ent_a;
    wr_data[~s1.cpar] = s1.z;
  end

  // Left neighbor is the center flag of the previous item in the row.
  always_ff @(posedge clk) begin
    if (s1.valid) begin
      left_flag <= center;
    end
  end

  always_comb begin
    result.frame_last = s1.last;
    if (center) begin
      result.out_alpha = 8'h00;
      result.out_red   = 8'h00;
      result.out_green = 8'h00;
      result.out_blue  = 8'h00;
    end else if (border) begin
      result.out_alpha = sos_pkg::OPAQUE;
      result.out_red   = sos_pkg::WHITE;
      result.out_green = sos_pkg::WHITE;
      result.out_blue  = sos_pkg::WHITE;
    end else begin
      result.out_alpha = sos_pkg::OPAQUE;
      result.out_red   = fill_red;
      result.out_green = fill_green;
      result.out_blue  = fill_blue;
    end
  end

  assign s1_push = s1.valid && s1.emit;

  sos_fifo u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (s1_push),
    .push_data (result),
    .valid     (rgba_valid),
    .stall     (rgba_stall),
    .data      (rgba_data),
    .count     (q_count)
  );

  // ---------------------------------------------------------------
  // Config and frame counters
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= sos_pkg::WIDTH_RESET;
      image_height <= sos_pkg::HEIGHT_RESET;
      fill_red     <= 8'h00;
      fill_green   <= 8'h00;
      fill_blue    <= 8'h00;
      in_col       <= '0;
      in_row       <= '0;
      out_col      <= '0;
      pending      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sos_pkg::REG_IMAGE_WIDTH: begin
          // Geometry change abandons the frame in progress.
          image_width <= cfg_data;
          in_col      <= '0;
          in_row      <= '0;
          out_col     <= '0;
          pending     <= '0;
        end
        sos_pkg::REG_IMAGE_HEIGHT: begin
          image_height <= cfg_data;
          in_col       <= '0;
          in_row       <= '0;
          out_col      <= '0;
          pending      <= '0;
        end
        sos_pkg::REG_FILL_RED:   fill_red   <= cfg_data[7:0];
        sos_pkg::REG_FILL_GREEN: fill_green <= cfg_data[7:0];
        sos_pkg::REG_FILL_BLUE:  fill_blue  <= cfg_data[7:0];
        default: begin
        end
      endcase
    end else if (go) begin
      if (pix_is) begin
        if (col_next_w == w_eff) begin
          in_col <= '0;
          in_row <= in_row_next;
          if (in_row_next >= h_eff) begin
            pending <= w_eff;
          end
        end else begin
          in_col <= in_col + AW'(1);
        end
      end else begin
        if (pending == WW'(1)) begin
          // Last flush: ready for the next frame.
          in_col  <= '0;
          in_row  <= '0;
          out_col <= '0;
          pending <= '0;
        end else begin
          pending <= pending - WW'(1);
          out_col <= out_col + AW'(1);
        end
      end
    end
  end

endmodule

`default_nettype wire

### src/sos_checker.sv
`default_nettype none

`include "sprite_outline_stencil_macros.svh"

module sos_checker (
  input logic           clk,
  input logic           rst,
  input logic           pix_stall,
  input logic           rgba_valid,
  input logic           rgba_stall,
  input sos_pkg::rgba_t rgba_data
);

  `SOS_CHECK_NEXT(a_out_hold, rgba_valid && rgba_stall,
    rgba_valid && $stable(rgba_data), "stalled output transaction changed")

  `SOS_CHECK(a_alpha_code, rgba_valid,
    rgba_data.out_alpha == 8'h00 || rgba_data.out_alpha == 8'hFF, "alpha not 0 or FF")

  `SOS_CHECK(a_transparent, rgba_valid && rgba_data.out_alpha == 8'h00,
    rgba_data.out_red == 8'h00 && rgba_data.out_green == 8'h00 &&
    rgba_data.out_blue == 8'h00, "transparent pixel with color")

  `SOS_CHECK(a_after_reset, $past(rst),
    !rgba_valid && !pix_stall, "output or stall right after reset")

endmodule

bind sprite_outline_stencil sos_checker u_sos_checker (
  .clk        (clk),
  .rst        (rst),
  .pix_stall  (pix_stall),
  .rgba_valid (rgba_valid),
  .rgba_stall (rgba_stall),
  .rgba_data  (rgba_data)
);

`default_nettype wire

### tb/sos_stencil_checker.sv
`timescale 1ns / 100ps

// Scoreboard for the outline stencil: watches the config port and both
// channels, keeps its own raster model and compares every RGBA transaction.
module sos_stencil_checker #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           pix_valid,
  input  logic                           pix_stall,
  input  sos_pkg::pix_t                  pix_data,
  input  logic                           rgba_valid,
  input  logic                           rgba_stall,
  input  sos_pkg::rgba_t                 rgba_data,
  input  logic                           cfg_we,
  input  logic [sos_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sos_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             mismatch_count,
  output int                             pending_results,
  output int                             results_checked,
  output int                             frames_done
);
  import sos_pkg::*;

  logic [8:0] width_reg, height_reg;
  logic [7:0] fill_red, fill_green, fill_blue;
  bit         zero_row [2][MAX_WIDTH];   // zero flags, one row per parity
  logic [8:0] in_col, in_row, out_col, out_row, owed;
  rgba_t      pending_rgba [$];
  int         errs, checked, frames;

  function automatic int eff_dim(logic [8:0] v, int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return int'(v);
  endfunction

  function automatic bit zero_at(int row, int col);
    return zero_row[row & 1][col];
  endfunction

  function automatic void restart_raster();
    in_col  = '0;
    in_row  = '0;
    out_col = '0;
    out_row = '0;
    owed    = '0;
  endfunction

  // RGBA for the pixel at (out_row, out_col).
  function automatic rgba_t shade_pixel(bit has_down, bit down_zero, bit last);
    int    w, r, c;
    bit    border;
    rgba_t px;
    w = eff_dim(width_reg, MAX_WIDTH);
    r = int'(out_row);
    c = int'(out_col);
    border = 1'b0;
    px.frame_last = last;
    if (zero_at(r, c)) begin
      px.out_alpha = '0;
      px.out_red   = '0;
      px.out_green = '0;
      px.out_blue  = '0;
      return px;
    end
    if (c > 0 && zero_at(r, c - 1)) border = 1'b1;
    if (c + 1 < w && zero_at(r, c + 1)) border = 1'b1;
    // row above lives in the other parity slot, same as row below it
    if (r > 0 && zero_at(r + 1, c)) border = 1'b1;
    if (has_down && down_zero) border = 1'b1;
    px.out_alpha = OPAQUE;
    if (border) begin
      px.out_red   = WHITE;
      px.out_green = WHITE;
      px.out_blue  = WHITE;
    end else begin
      px.out_red   = fill_red;
      px.out_green = fill_green;
      px.out_blue  = fill_blue;
    end
    return px;
  endfunction

  task automatic advance_raster(pix_t item);
    int w, h;
    bit is_zero;
    w = eff_dim(width_reg, MAX_WIDTH);
    h = eff_dim(height_reg, MAX_HEIGHT);
    is_zero = (item.pixel_value == 8'd0);
    if (item.op == OP_PIXEL) begin
      if (in_row >= h || in_col >= w) return;
      if (in_row > 0) begin
        pending_rgba.push_back(shade_pixel(1'b1, is_zero, 1'b0));
        out_col = out_col + 1;
        if (out_col >= w) begin
          out_col = '0;
          out_row = out_row + 1;
        end
      end
      zero_row[in_row[0]][in_col] = is_zero;
      in_col = in_col + 1;
      if (in_col >= w) begin
        in_col = '0;
        in_row = in_row + 1;
        if (in_row >= h) owed = w[8:0];
      end
    end else begin
      if (owed == 0 || out_col >= w) return;
      owed = owed - 1;
      pending_rgba.push_back(shade_pixel(1'b0, 1'b0, owed == 0));
      out_col = out_col + 1;
      if (owed == 0) begin
        restart_raster();
        frames++;
      end
    end
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    case (idx)
      REG_IMAGE_WIDTH: begin
        width_reg = value;
        restart_raster();
      end
      REG_IMAGE_HEIGHT: begin
        height_reg = value;
        restart_raster();
      end
      REG_FILL_RED:   fill_red   = value[7:0];
      REG_FILL_GREEN: fill_green = value[7:0];
      REG_FILL_BLUE:  fill_blue  = value[7:0];
      default: ;
    endcase
  endtask

  task automatic check_byte(string field, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %02h, got %02h", field, want, got);
      errs++;
    end
  endtask

  task automatic check_result(rgba_t got);
    rgba_t want;
    if (pending_rgba.size() == 0) begin
      $error("RGBA transaction with nothing expected: %h", got);
      errs++;
      return;
    end
    want = pending_rgba.pop_front();
    checked++;
    check_byte("out_alpha", want.out_alpha, got.out_alpha);
    check_byte("out_red", want.out_red, got.out_red);
    check_byte("out_green", want.out_green, got.out_green);
    check_byte("out_blue", want.out_blue, got.out_blue);
    check_byte("frame_last", 8'(want.frame_last), 8'(got.frame_last));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      width_reg  = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      fill_red   = '0;
      fill_green = '0;
      fill_blue  = '0;
      restart_raster();
      pending_rgba.delete();
    end else begin
      if (cfg_we) write_register(cfg_index, cfg_data);
      if (pix_valid && !pix_stall) advance_raster(pix_data);
      if (rgba_valid && !rgba_stall) check_result(rgba_data);
    end
    mismatch_count  <= errs;
    pending_results <= pending_rgba.size();
    results_checked <= checked;
    frames_done     <= frames;
  end

endmodule

### tb/sprite_outline_stencil_tb.sv
`timescale 1ns / 100ps

// Top of the outline stencil bench: drives pixel/flush transactions and config
// writes, randomizes both sides' idling, and gives the verdict. Result comparison
// lives in sos_stencil_checker.
module sprite_outline_stencil_tb;
  import sos_pkg::*;

  localparam int MAX_W         = 256;
  localparam int MAX_H         = 256;
  localparam int ITEM_BUDGET   = 1700;  // counted frame pixels and flushes
  localparam int LONG_HOLD     = 96;    // receiver hold-off, in cycles
  localparam int SETTLE_CYCLES = 4;     // pipeline is two deep; a bit of margin
  localparam int QUIET_LIMIT   = 4000;  // cycles with no transaction at all

  logic                  clk        = 1'b0;
  logic                  rst        = 1'b1;
  logic                  pix_valid  = 1'b0;
  pix_t                  pix_data   = '0;
  logic                  pix_stall;
  logic                  rgba_valid;
  logic                  rgba_stall = 1'b0;
  rgba_t                 rgba_data;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  int mismatch_count, pending_results, results_checked, frames_done;

  // Idle mix, changed by the stimulus as the run goes on.
  int send_idle_pct  = 17;
  int recv_stall_pct = 76;

  // Long receiver hold-off: stimulus bumps requests, receiver serves them.
  int hold_requests = 0;
  int hold_served   = 0;
  int hold_left     = 0;

  int counted     = 0;
  int pixel_sent  = 0;
  int flush_sent  = 0;
  int quiet_cycles = 0;

  // tb copy of the size registers, only for sizing frames
  logic [8:0] width_now  = WIDTH_RESET;
  logic [8:0] height_now = HEIGHT_RESET;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  sprite_outline_stencil #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pix_data  (pix_data),
    .rgba_valid(rgba_valid),
    .rgba_stall(rgba_stall),
    .rgba_data (rgba_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  sos_stencil_checker #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) u_checker (
    .clk            (clk),
    .rst            (rst),
    .pix_valid      (pix_valid),
    .pix_stall      (pix_stall),
    .pix_data       (pix_data),
    .rgba_valid     (rgba_valid),
    .rgba_stall     (rgba_stall),
    .rgba_data      (rgba_data),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .pending_results(pending_results),
    .results_checked(results_checked),
    .frames_done    (frames_done)
  );

  // Receiver: random stalls, or a long hold-off when one is requested. The
  // hold is counted here so the sender keeps pushing and the block backs up.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      rgba_stall <= 1'b1;
      hold_left  <= hold_left - 1;
    end else if (hold_served != hold_requests) begin
      rgba_stall  <= 1'b1;
      hold_served <= hold_served + 1;
      hold_left   <= LONG_HOLD;
    end else begin
      rgba_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog: any stretch without a transaction on either channel is bounded.
  always @(posedge clk) begin
    if (rst || (pix_valid && !pix_stall) || (rgba_valid && !rgba_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: %0d results still expected", pending_results);
        $display("sprite_outline_stencil: mismatch");
        $finish;
      end
    end
  end

  function automatic int clamp_dim(int v, int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [7:0] draw_pixel(int zero_pct);
    if ($urandom_range(99) < zero_pct) return 8'd0;
    return 8'($urandom_range(255, 1));
  endfunction

  // One transaction on the pixel channel. Idle cycles come first, decided by
  // dice only, so valid never follows stall.
  task automatic offer(logic op, logic [7:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      pix_valid <= 1'b0;
      @(posedge clk);
    end
    pix_valid <= 1'b1;
    pix_data  <= {op, value};
    do @(posedge clk); while (pix_stall);
    if (op == OP_FLUSH) flush_sent++;
    else pixel_sent++;
  endtask

  // Drop valid and wait until every expected result is back, then let the
  // pipeline settle so a pixel that gave no result is also absorbed.
  task automatic quiesce();
    pix_valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Only called while idle. The idle step after the write keeps cfg_we to one update per step.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == REG_IMAGE_WIDTH) width_now = value;
    if (idx == REG_IMAGE_HEIGHT) height_now = value;
  endtask

  // Fill bytes: favor the extremes now and then.
  task automatic random_fills();
    logic [CFG_IDX_W-1:0] regs [3];
    regs = '{REG_FILL_RED, REG_FILL_GREEN, REG_FILL_BLUE};
    foreach (regs[i]) begin
      case ($urandom_range(3))
        0: write_reg(regs[i], 9'd0);
        1: write_reg(regs[i], 9'd255);
        default: write_reg(regs[i], 9'($urandom_range(255)));
      endcase
    end
  endtask

  // Noise: a flush before the frame is complete is ignored by the block.
  task automatic send_pixels(int n, int zero_pct, bit noisy);
    for (int i = 0; i < n; i++) begin
      if (noisy && $urandom_range(9) == 0) offer(OP_FLUSH, draw_pixel(50));
      offer(OP_PIXEL, draw_pixel(zero_pct));
      counted++;
    end
  endtask

  // Noise: a pixel while flushes are owed is ignored too. Never after the
  // last flush, since that pixel would open the next frame.
  task automatic send_flushes(int n, bit noisy);
    for (int i = 0; i < n; i++) begin
      if (noisy && $urandom_range(4) == 0) offer(OP_PIXEL, draw_pixel(50));
      offer(OP_FLUSH, draw_pixel(50));
      counted++;
    end
  endtask

  task automatic run_frame(int zero_pct, bit noisy);
    int w, h;
    w = clamp_dim(int'(width_now), MAX_W);
    h = clamp_dim(int'(height_now), MAX_H);
    send_pixels(w * h, zero_pct, noisy);
    send_flushes(w, noisy);
  endtask

  initial begin
    logic [7:0] demo [9];
    int         w_eff, h_eff, n, k, kind, zero_pct, phase_no;
    bit         need_restart;
    logic [8:0] w_sel, h_sel;

    // 3x3 sprite: zero at bottom-left, so its right and upper neighbors are
    // border pixels, the center keeps the fill colour.
    demo = '{8'h01, 8'hFF, 8'h80,
             8'h7F, 8'h42, 8'h10,
             8'h00, 8'h20, 8'h04};

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---- directed ----
    // flush with nothing owed: ignored
    offer(OP_FLUSH, 8'hFF);
    quiesce();
    // zero sizes clamp to a 1x1 image
    write_reg(REG_IMAGE_WIDTH, 9'd0);
    write_reg(REG_IMAGE_HEIGHT, 9'd0);
    write_reg(REG_FILL_RED, 9'd255);
    write_reg(REG_FILL_GREEN, 9'd0);
    write_reg(REG_FILL_BLUE, 9'd255);
    // lone opaque pixel has no neighbors: fill colour, frame_last on the flush;
    // the second pixel arrives after the frame is complete and is ignored
    offer(OP_PIXEL, 8'hFF);
    offer(OP_PIXEL, 8'h01);
    offer(OP_FLUSH, 8'h00);
    // transparent pixel
    offer(OP_PIXEL, 8'h00);
    offer(OP_FLUSH, 8'hFF);
    quiesce();
    write_reg(REG_IMAGE_WIDTH, 9'd3);
    write_reg(REG_IMAGE_HEIGHT, 9'd3);
    write_reg(REG_FILL_RED, 9'h5A);
    write_reg(REG_FILL_GREEN, 9'hA5);
    write_reg(REG_FILL_BLUE, 9'h3C);
    foreach (demo[i]) begin
      offer(OP_PIXEL, demo[i]);
      if (i == 3) offer(OP_FLUSH, 8'h80);   // early flush, frame incomplete
    end
    offer(OP_PIXEL, 8'h55);                 // frame already complete
    for (int i = 0; i < 3; i++) offer(OP_FLUSH, 8'h00);
    counted += 15;

    // ---- random ----
    phase_no     = 0;
    need_restart = 1'b1;
    while (counted < ITEM_BUDGET) begin
      // idle mix: sender light / receiver heavy, then swapped, then none
      if (counted < ITEM_BUDGET / 3) begin
        send_idle_pct  = 17;
        recv_stall_pct = 76;
      end else if (counted < 2 * ITEM_BUDGET / 3) begin
        send_idle_pct  = 76;
        recv_stall_pct = 17;
      end else begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end

      zero_pct = $urandom_range(4) * 25;
      quiesce();

      case (phase_no)
        4: begin
          // widest row, register above range; the row's flush results pile
          // up against a long receiver hold-off
          write_reg(REG_IMAGE_WIDTH, 9'd511);
          write_reg(REG_IMAGE_HEIGHT, 9'd1);
          random_fills();
          send_pixels(MAX_W, 30, 1'b0);
          hold_requests++;
          send_flushes(MAX_W, 1'b0);
        end
        9: begin
          // tallest column, height register above range
          write_reg(REG_IMAGE_WIDTH, 9'd1);
          write_reg(REG_IMAGE_HEIGHT, 9'd511);
          random_fills();
          run_frame(40, 1'b1);
        end
        14: begin
          // exact maximum width, abandoned early in the second row
          write_reg(REG_IMAGE_WIDTH, 9'd256);
          write_reg(REG_IMAGE_HEIGHT, 9'd2);
          send_pixels(256 + $urandom_range(60, 10), 20, 1'b0);
          need_restart = 1'b1;
        end
        default: begin
          if (need_restart || $urandom_range(3) != 0) begin
            w_sel = 9'($urandom_range(10, 1));
            h_sel = 9'($urandom_range(6, 1));
            if ($urandom_range(19) == 0) w_sel = 9'd0;
            if ($urandom_range(19) == 0) h_sel = 9'd0;
            write_reg(REG_IMAGE_WIDTH, w_sel);
            write_reg(REG_IMAGE_HEIGHT, h_sel);
            need_restart = 1'b0;
          end
          if ($urandom_range(1) == 0) random_fills();
          if (phase_no == 20) hold_requests++;

          w_eff = clamp_dim(int'(width_now), MAX_W);
          h_eff = clamp_dim(int'(height_now), MAX_H);
          n     = w_eff * h_eff;
          kind  = $urandom_range(99);
          if (kind < 65 || (kind >= 78 && kind < 88 && n < 2)) begin
            run_frame(zero_pct, 1'b0);
          end else if (kind < 78) begin
            run_frame(zero_pct, 1'b1);
          end else if (kind < 88) begin
            // fill colour changes partway through the frame
            k = $urandom_range(n - 1, 1);
            send_pixels(k, zero_pct, 1'b0);
            quiesce();
            random_fills();
            send_pixels(n - k, zero_pct, 1'b0);
            send_flushes(w_eff, 1'b0);
          end else begin
            // frame dropped part way (possibly with flushes still owed);
            // the next size write restarts the raster
            send_pixels($urandom_range(n, 1), zero_pct, 1'b1);
            need_restart = 1'b1;
          end
        end
      endcase
      phase_no++;
    end

    quiesce();
    repeat (8) @(posedge clk);

    $display("ran %0d pixel and %0d flush transactions, %0d results checked, %0d frames closed",
             pixel_sent, flush_sent, results_checked, frames_done);
    $display("sizes 1x1 to 256 wide / 256 tall incl. clamped registers, fill changes, dropped frames");
    if (mismatch_count == 0) begin
      $display("sprite_outline_stencil: match");
    end else begin
      $display("sprite_outline_stencil: mismatch");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+src
src/sos_pkg.sv
src/sos_ram.sv
src/sos_fifo.sv
src/sprite_outline_stencil.sv
src/sos_checker.sv
tb/sos_stencil_checker.sv
tb/sprite_outline_stencil_tb.sv
